### sv/brsp_pkg.sv
// Shared types and constants for the base relocation stream parser.
`timescale 1ns / 1ps
`default_nettype none
package brsp_pkg;

	localparam logic [15:0] TYPE_MASK  = 16'hF000;
	localparam logic [15:0] OFFS_MASK  = 16'h0FFF;
	localparam int          TYPE_SHIFT = 12;

	// Entry types that produce a patch command.
	localparam logic [3:0] RTYPE_HIGH = 4'd1;
	localparam logic [3:0] RTYPE_LOW  = 4'd2;
	localparam logic [3:0] RTYPE_WORD = 4'd3;

	typedef enum logic [4:0] {
		PH_PAGE_LO = 5'b00001,
		PH_PAGE_HI = 5'b00010,
		PH_SIZE_LO = 5'b00100,
		PH_SIZE_HI = 5'b01000,
		PH_ENTRY   = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HIGH = 3'd0,
		KIND_LOW  = 3'd1,
		KIND_WORD = 3'd2,
		KIND_END  = 3'd3,
		KIND_BAD  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] target_offset;
		logic [31:0] addend;
	} patch_t;

	typedef struct packed {
		logic   valid;
		patch_t patch;
	} result_t;

	typedef struct packed {
		logic   halted;
		phase_t phase;
	} parse_status_t;

endpackage
`default_nettype wire

### sv/base_relocation_stream_parser.sv
// Top level of the base relocation stream parser.
// A word accepted into the input register is decoded into the output register, or
// into the skid stage while the output register is occupied. Throughput: one word
// per cycle while the skid stage is empty, limited by the phase update and offset add.
// Reset: arst_n clears the parser to expect a page address low half, empties all
// stages and sets load_delta to zero.
`timescale 1ns / 1ps
`default_nettype none
module base_relocation_stream_parser import brsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] half,
	input  wire logic        first,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [31:0]      target_offset,
	output logic [31:0]      addend,
	input  wire logic        load_delta_we,
	input  wire logic [31:0] load_delta_wdata
);

	// Configuration register; user must write it only while the parser is idle (unchecked).
	logic [31:0] load_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_delta_q <= 32'd0;
		end else if (load_delta_we) begin
			load_delta_q <= load_delta_wdata;
		end
	end

	// Input register. A word held here is decoded as soon as the output side
	// has room for one more command, which is whenever the skid stage is empty.
	// Words that produce no command still wait for that room, which keeps the
	// rule simple and costs nothing in steady state.
	logic          v_s1;
	logic [15:0]   half_s1;
	logic          first_s1;
	logic          adv;
	logic          in_accept;
	logic          skid_full;
	result_t       res;
	parse_status_t status;
	patch_t        out_data;

	assign adv       = v_s1 && !skid_full;
	assign in_ready  = !v_s1 || adv;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_accept || (v_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			half_s1  <= half;
			first_s1 <= first;
		end
	end

	// Header and entry decode; the parser state advances once per decoded word.
	brsp_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.half       (half_s1),
		.first      (first_s1),
		.load_delta (load_delta_q),
		.res        (res),
		.status     (status)
	);

	// The output register plus a skid stage let the input side keep moving
	// while a finished command waits for the consumer.
	brsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && res.valid),
		.push_data (res.patch),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.skid_full (skid_full)
	);

	assign kind          = out_data.kind;
	assign target_offset = out_data.target_offset;
	assign addend        = out_data.addend;

	// A command is never pushed while the skid stage is still occupied.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.valid) |-> !skid_full)
		else $error("command pushed into a full output buffer");

	// The skid stage only holds a command when the output register does too.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> out_valid)
		else $error("skid stage valid with empty output register");

	// A halted parser stays silent until a word marks a new directory.
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && status.halted && !first_s1) |-> !res.valid)
		else $error("command produced while halted");

	// End and malformed reports carry zero offset and addend.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_END || kind == KIND_BAD))
		|-> (target_offset == 32'd0 && addend == 32'd0))
		else $error("end or malformed report with nonzero payload");

endmodule
`default_nettype wire

### sv/brsp_decode.sv
// Parser state and the per-word decode of the relocation directory.
`timescale 1ns / 1ps
`default_nettype none
module brsp_decode import brsp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [15:0]   half,
	input  wire logic          first,
	input  wire logic [31:0]   load_delta,
	output result_t            res,
	output parse_status_t      status
);

	phase_t      phase_q, phase_d, eff_phase;
	logic [31:0] page_q, page_d;
	logic [15:0] size_lo_q, size_lo_d;
	logic [30:0] left_q, left_d, eff_left, left_dec;
	logic        halted_q, halted_d, eff_halted;
	logic [31:0] size;
	logic [3:0]  rtype;
	logic [31:0] tgt;

	assign status.halted = halted_q;
	assign status.phase  = phase_q;

	always_comb begin
		eff_phase  = first ? PH_PAGE_LO : phase_q;
		eff_halted = first ? 1'b0 : halted_q;
		eff_left   = first ? 31'd0 : left_q;
		size       = {half, size_lo_q};
		rtype      = 4'((half & TYPE_MASK) >> TYPE_SHIFT);
		tgt        = page_q + {16'd0, half & OFFS_MASK};
		left_dec   = eff_left - 31'd1;

		phase_d    = eff_phase;
		page_d     = page_q;
		size_lo_d  = size_lo_q;
		left_d     = eff_left;
		halted_d   = eff_halted;
		res        = '0;
		res.patch.kind = KIND_HIGH;

		if (!eff_halted) begin
			unique case (eff_phase)
				PH_PAGE_HI: begin
					page_d  = {half, page_q[15:0]};
					phase_d = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					size_lo_d = half;
					phase_d   = PH_SIZE_HI;
				end
				PH_SIZE_HI: begin
					if (size == 32'd0) begin
						halted_d       = 1'b1;
						phase_d        = PH_PAGE_LO;
						res.valid      = 1'b1;
						res.patch.kind = KIND_END;
					end else if (size[31:3] == 29'd0 || size[0]) begin
						halted_d       = 1'b1;
						phase_d        = PH_PAGE_LO;
						res.valid      = 1'b1;
						res.patch.kind = KIND_BAD;
					end else begin
						// (size - 8) / 2 for an even size of at least eight.
						left_d  = size[31:1] - 31'd4;
						phase_d = (left_d != 31'd0) ? PH_ENTRY : PH_PAGE_LO;
					end
				end
				PH_ENTRY: begin
					left_d = left_dec;
					if (left_dec == 31'd0) begin
						phase_d = PH_PAGE_LO;
					end
					res.patch.target_offset = tgt;
					if (rtype == RTYPE_HIGH) begin
						res.valid           = 1'b1;
						res.patch.kind      = KIND_HIGH;
						res.patch.addend    = {16'd0, load_delta[31:16]};
					end else if (rtype == RTYPE_LOW) begin
						res.valid           = 1'b1;
						res.patch.kind      = KIND_LOW;
						res.patch.addend    = {16'd0, load_delta[15:0]};
					end else if (rtype == RTYPE_WORD) begin
						res.valid           = 1'b1;
						res.patch.kind      = KIND_WORD;
						res.patch.addend    = load_delta;
					end else begin
						res.patch.target_offset = 32'd0;
					end
				end
				default: begin
					// Page low half, and any code that should never occur.
					page_d  = {16'd0, half};
					phase_d = PH_PAGE_HI;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PAGE_LO;
			page_q    <= 32'd0;
			size_lo_q <= 16'd0;
			left_q    <= 31'd0;
			halted_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			page_q    <= page_d;
			size_lo_q <= size_lo_d;
			left_q    <= left_d;
			halted_q  <= halted_d;
		end
	end

endmodule
`default_nettype wire

### sv/brsp_out_buf.sv
// Output register with a skid stage for patch commands.
`timescale 1ns / 1ps
`default_nettype none
module brsp_out_buf import brsp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  patch_t      push_data,
	input  wire logic   out_ready,
	output logic        out_valid,
	output patch_t      out_data,
	output logic        skid_full
);

	logic   main_v_q, skid_v_q;
	patch_t main_q, skid_q;
	logic   pop;

	assign pop       = main_v_q && out_ready;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign skid_full = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push && (!main_v_q || pop)) begin
				main_v_q <= 1'b1;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end else if (pop) begin
				main_v_q <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (push && (!main_v_q || pop)) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end
	end

endmodule
`default_nettype wire
